// File: rtl/mme_pkg.sv
// Shared constants, codes and word types of the modulation matrix engine
package mme_pkg;

  localparam int NODES   = 32;
  localparam int NODE_W  = $clog2(NODES);
  localparam int NPAR    = 8;
  localparam int PAR_W   = $clog2(NPAR);
  localparam int NCHAN   = 8;
  localparam int CHAN_W  = $clog2(NCHAN);
  localparam int DW      = 8;
  localparam int PADDR_W = NODE_W + PAR_W;
  localparam int K_W     = $clog2(NPAR + 3);

  localparam logic [1:0] ACT_OP    = 2'd0;
  localparam logic [1:0] ACT_PARAM = 2'd1;
  localparam logic [1:0] ACT_INPUT = 2'd2;
  localparam logic [1:0] ACT_RUN   = 2'd3;

  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_TRUE  = 2'd1;
  localparam logic [1:0] CFG_FALSE = 2'd2;

  localparam logic [4:0] OP_SUM    = 5'd0;
  localparam logic [4:0] OP_PROD   = 5'd1;
  localparam logic [4:0] OP_NEG    = 5'd2;
  localparam logic [4:0] OP_INV    = 5'd3;
  localparam logic [4:0] OP_RAMP   = 5'd4;
  localparam logic [4:0] OP_LFO    = 5'd5;
  localparam logic [4:0] OP_DELAY  = 5'd6;
  localparam logic [4:0] OP_SH     = 5'd7;
  localparam logic [4:0] OP_SWITCH = 5'd8;
  localparam logic [4:0] OP_CMP    = 5'd9;
  localparam logic [4:0] OP_MIN    = 5'd10;
  localparam logic [4:0] OP_MAX    = 5'd11;
  localparam logic [4:0] OP_SCALE  = 5'd12;
  localparam logic [4:0] OP_EDGE   = 5'd13;
  localparam logic [4:0] OP_AND    = 5'd14;
  localparam logic [4:0] OP_OR     = 5'd15;
  localparam logic [4:0] OP_XOR    = 5'd16;
  localparam logic [4:0] OP_NOT    = 5'd17;
  localparam logic [4:0] OP_INPUT  = 5'd18;
  localparam logic [4:0] OP_OUTPUT = 5'd19;
  localparam logic [4:0] OP_GLIDE  = 5'd20;
  localparam logic [4:0] OP_NONE   = 5'd21;

  typedef struct packed {
    logic [1:0]        action;
    logic [4:0]        node_index;
    logic [4:0]        op_code;
    logic [3:0]        param_count;
    logic [2:0]        param_index;
    logic signed [7:0] param_value;
    logic              param_is_constant;
    logic [2:0]        input_channel;
    logic signed [7:0] input_value;
  } cmd_t;

  typedef struct packed {
    logic              output_valid;
    logic [2:0]        output_channel;
    logic signed [7:0] output_value;
    logic              run_done;
  } res_t;

endpackage

// File: rtl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data
module mme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/modulation_matrix_engine.sv
// Modulation matrix engine top level: node sequencer, parameter and result memories
// Write words (node op, node parameter, input channel) never raise busy.
// A run word walks node 0 to node_count-1 (at most 32); each node fetches all eight
// parameter slots through the parameter RAM and then the result RAM, one slot a cycle,
// then evaluates in S_EXEC; product nodes then run the 8x8 multiplier in S_MUL. busy rises in
// the cycle after the run word and stays high until the run is over; a run with no
// nodes keeps it high for one cycle. Output nodes and the closing run_done word appear
// on result for one cycle each with result_valid high; the receiver cannot stall, so it
// must take every word as it comes. busy is already low in the cycle that shows run_done,
// so the next word can be taken at the edge that ends it.
module modulation_matrix_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mme_pkg::cmd_t       cmd,
  output logic                result_valid,
  output mme_pkg::res_t       result,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import mme_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]              state;
  logic [5:0]              node_count;
  logic signed [7:0]       true_level, false_level;
  logic [4:0]              ops [NODES];
  logic [3:0]              pcnt [NODES];
  logic [NPAR-1:0]         cflags [NODES];
  logic signed [15:0]      ctr [NODES];
  logic [7:0]              nflags [NODES];
  logic signed [7:0]       inbuf [NCHAN];
  logic [NODES-1:0]        rvalid;
  logic [NODE_W-1:0]       n;
  logic [K_W-1:0]          k, km1, km2;
  logic [3:0]              j;
  logic [5:0]              total, total_v;

  logic signed [7:0]       raw_q [NPAR];
  logic signed [7:0]       p [NPAR];
  logic signed [7:0]       r_old, acc, pend_raw, fetched;
  logic                    pend_const, pend_ok, pend_valid;

  logic                    accept;
  logic                    p_we;
  logic [PADDR_W-1:0]      p_waddr, p_raddr;
  logic [7:0]              p_rdata;
  logic [NODE_W-1:0]       r_raddr;
  logic [7:0]              r_rdata;
  logic                    commit;
  logic signed [7:0]       r_calc, r_w;
  logic signed [15:0]      ctr_new;
  logic [7:0]              flg_new;
  logic [4:0]              op;
  logic [3:0]              cnt;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign op      = ops[n];
  assign cnt     = pcnt[n];
  assign km1     = k - K_W'(1);
  assign km2     = k - K_W'(2);
  assign total_v = (node_count > 6'(NODES)) ? 6'(NODES) : node_count;

  assign p_we    = accept && (cmd.action == ACT_PARAM);
  assign p_waddr = {cmd.node_index, cmd.param_index};
  assign p_raddr = {n, k[PAR_W-1:0]};
  assign r_raddr = (k == K_W'(NPAR + 1)) ? n : p_rdata[NODE_W-1:0];

  assign fetched = pend_const ? pend_raw : ((pend_ok && pend_valid) ? $signed(r_rdata) : 8'sd0);

  assign commit = (state == S_EXEC && op != OP_PROD) || (state == S_MUL && j >= cnt);
  assign r_w    = (state == S_MUL) ? acc : r_calc;

  mme_ram #(.WIDTH(DW), .DEPTH(NODES * NPAR)) u_params (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(cmd.param_value),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  mme_ram #(.WIDTH(DW), .DEPTH(NODES)) u_results (
    .clk(clk), .we(commit), .waddr(n), .wdata(r_w),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // node evaluation
  always_comb begin
    logic signed [7:0]  sum, mn, mx, ch, gmx;
    logic               any_le, any_gt, up;
    logic signed [15:0] hs, c16, prod;
    logic signed [17:0] inc, hs18;
    logic signed [8:0]  nmx;
    sum = '0; mn = 8'sd127; mx = -8'sd128; any_le = 1'b0; any_gt = 1'b0;
    for (int i = 0; i < NPAR; i++) begin
      if (i < int'(cnt)) begin
        sum = sum + p[i];
        if (p[i] < mn) mn = p[i];
        if (p[i] > mx) mx = p[i];
        if (p[i] <= 0) any_le = 1'b1;
        if (p[i] > 0)  any_gt = 1'b1;
      end
    end
    hs   = ctr[n];
    hs18 = {{2{hs[15]}}, hs};
    up   = raw_q[3][1];
    inc  = {{2{p[0][7]}}, p[0], 8'h00};
    if (!up) inc = -inc;
    c16  = hs + 16'sd1;
    prod = p[0] * p[1];
    ch   = p[0] - r_old;
    gmx  = p[1];
    nmx  = -{gmx[7], gmx};
    r_calc  = r_old;
    ctr_new = hs;
    flg_new = nflags[n];
    unique case (op)
      OP_SUM:    r_calc = sum;
      OP_NEG:    r_calc = (p[0] == -8'sd128) ? 8'sd127 : -p[0];
      OP_INV:    r_calc = ~p[0] ^ 8'sh80;
      OP_RAMP: begin
        if (p[1] != 0) begin
          ctr_new = {p[2], 8'h00};
          flg_new = nflags[n] | 8'h01;
        end else if (nflags[n][0]) begin
          if ((up && (hs < 0 || (18'sd32767 - hs18) > inc)) ||
              (!up && (hs > 0 || (-18'sd32768 - hs18) <= inc))) begin
            ctr_new = hs + inc[15:0];
          end else begin
            flg_new = nflags[n] & 8'hFE;
            if (raw_q[3][0]) ctr_new = {p[2], 8'h00};
          end
        end
        r_calc = ctr_new[15:8];
      end
      OP_LFO: begin
        if (p[2] != 0) begin
          r_calc  = raw_q[5][0] ? p[3] : p[4];
          ctr_new = '0;
        end else begin
          if (c16 == 16'(p[1]) || c16 == 16'(p[0]))
            r_calc = (r_old > 0) ? p[4] : p[3];
          ctr_new = (c16 == 16'(p[0])) ? 16'sd0 : c16;
        end
      end
      OP_DELAY:  r_calc = p[0];
      OP_SH: begin
        if (p[2] != 0) r_calc = '0;
        else if (p[1] != 0) r_calc = p[0];
      end
      OP_SWITCH: r_calc = (p[1] != 0) ? p[0] : 8'sd0;
      OP_CMP:    r_calc = (p[0] > p[1]) ? true_level : false_level;
      OP_MIN:    r_calc = mn;
      OP_MAX:    r_calc = mx;
      OP_SCALE: begin
        if ((p[0] == 8'sd127 && p[1] == 8'sd127) || (p[0] <= -8'sd127 && p[1] <= -8'sd127))
          r_calc = 8'sd127;
        else
          r_calc = prod[14:7];
      end
      OP_EDGE: begin
        if (p[0] > 0) begin
          if (nflags[n] == 8'h00) begin
            r_calc  = 8'sd127;
            flg_new = 8'h7F;
          end else begin
            r_calc = '0;
          end
        end else begin
          flg_new = 8'h00;
        end
      end
      OP_AND:    r_calc = any_le ? false_level : true_level;
      OP_OR:     r_calc = any_gt ? true_level : false_level;
      OP_XOR:    r_calc = ((p[0] > 0) != (p[1] > 0)) ? true_level : false_level;
      OP_NOT:    r_calc = (p[0] > 0) ? false_level : true_level;
      OP_INPUT:
        r_calc = (p[0][7:CHAN_W] == '0) ? inbuf[p[0][CHAN_W-1:0]] : 8'sd0;
      OP_GLIDE: begin
        if (ch > 0 && p[2] != 0)
          r_calc = (ch > gmx) ? r_old + gmx : r_old + ch;
        else if (ch < 0 && p[3] != 0)
          r_calc = ($signed({ch[7], ch}) < nmx) ? r_old - gmx : r_old + ch;
        else
          r_calc = p[0];
      end
      default: r_calc = r_old;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      node_count   <= '0;
      true_level   <= 8'sd127;
      false_level  <= 8'sd0;
      rvalid       <= '0;
      result_valid <= 1'b0;
      n            <= '0;
      k            <= '0;
      j            <= '0;
      total        <= '0;
      for (int i = 0; i < NODES; i++) begin
        ops[i]    <= OP_NONE;
        pcnt[i]   <= '0;
        cflags[i] <= '0;
        ctr[i]    <= '0;
        nflags[i] <= '0;
      end
      for (int i = 0; i < NCHAN; i++) inbuf[i] <= '0;
    end else begin
      result_valid <= (commit && op == OP_OUTPUT) || (state == S_DONE);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COUNT: node_count  <= cfg_data[5:0];
          CFG_TRUE:  true_level  <= cfg_data;
          CFG_FALSE: false_level <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.action)
              ACT_OP: begin
                ops[cmd.node_index]  <= cmd.op_code;
                pcnt[cmd.node_index] <= (cmd.param_count > 4'(NPAR)) ? 4'(NPAR)
                                                                     : cmd.param_count;
              end
              ACT_PARAM: cflags[cmd.node_index][cmd.param_index] <= cmd.param_is_constant;
              ACT_INPUT: inbuf[cmd.input_channel] <= cmd.input_value;
              ACT_RUN: begin
                total <= total_v;
                n     <= '0;
                k     <= '0;
                state <= (total_v == 6'd0) ? S_DONE : S_FETCH;
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          k <= k + K_W'(1);
          if (k == K_W'(NPAR + 2)) state <= S_EXEC;
        end
        S_EXEC: begin
          ctr[n]    <= ctr_new;
          nflags[n] <= flg_new;
          j         <= 4'd1;
          if (op == OP_PROD) state <= S_MUL;
        end
        S_MUL: begin
          if (j < cnt) j <= j + 4'd1;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (commit) begin
        rvalid[n] <= 1'b1;
        k <= '0;
        if ({1'b0, n} == total - 6'd1) begin
          state <= S_DONE;
        end else begin
          n     <= n + NODE_W'(1);
          state <= S_FETCH;
        end
      end
    end
  end

  // fetch pipeline and result word, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      pend_raw   <= p_rdata;
      pend_const <= (k <= K_W'(NPAR) && k != '0) ? cflags[n][km1[PAR_W-1:0]] : 1'b0;
      pend_ok    <= (k == K_W'(NPAR + 1)) ? 1'b1 : (p_rdata[7:NODE_W] == '0);
      pend_valid <= rvalid[r_raddr];
      if (k != '0 && k <= K_W'(NPAR)) raw_q[km1[PAR_W-1:0]] <= p_rdata;
      if (k >= K_W'(2) && k <= K_W'(NPAR + 1)) p[km2[PAR_W-1:0]] <= fetched;
      if (k == K_W'(NPAR + 2)) r_old <= fetched;
    end
    if (state == S_EXEC) acc <= p[0];
    if (state == S_MUL && j < cnt) acc <= 8'(acc * p[j[PAR_W-1:0]]);
    if (commit && op == OP_OUTPUT)
      result <= '{output_valid: 1'b1, output_channel: p[0][2:0],
                  output_value: p[1], run_done: 1'b0};
    if (state == S_DONE)
      result <= '{output_valid: 1'b0, output_channel: 3'd0,
                  output_value: 8'sd0, run_done: 1'b1};
  end
endmodule
